// ----- design/aesbe_pkg.sv -----
// Shared types and constants for the AES block encryption core.
// Holds the S-box table, the xtime helper, the state machine type and mode codes.
// No dependencies.
package aesbe_pkg;

    // Mode register codes
    localparam logic [1:0] MODE_128 = 2'd0;
    localparam logic [1:0] MODE_192 = 2'd1;
    localparam logic [1:0] MODE_256 = 2'd2;

    // Request kinds
    localparam logic REQ_KEY = 1'b0;
    localparam logic REQ_ENC = 1'b1;

    // Number of bytes in one block
    localparam int BLOCK_BYTES = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_OUT
    } ctrl_state_t;

    // Control signals from the controller to the byte datapath
    typedef struct packed {
        logic       load;
        logic       step;
        logic       mix;
        logic       last_byte;
    } dp_ctrl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

// ----- design/aes_block_encrypt_top.sv -----
// AES-128/192/256 encryption core with a loaded round-key schedule.
// An encrypt item runs an initial key addition one column at a time, then moves
// one state byte through the S-box per cycle over Nr rounds (Nr = 10/12/14).
// Key writes go straight into the key memory. The core takes one item at a time:
// after an encrypt item no new item is accepted until its result has been taken.
// Reset (rst_n, async, active low) clears control and the mode to 10 rounds;
// key memory contents are undefined until written.
module aes_block_encrypt_top #(
    parameter int KEY_WORDS = 60
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: key_index[5:0], key_word[37:6], plain_w0..w3[165:38]; zero pad to 168
    input  logic [167:0] s_tdata,
    // tuser: req_type
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: cipher_w0[31:0], w1[63:32], w2[95:64], w3[127:96]
    output logic [127:0] m_tdata
);

    localparam int AW = $clog2(KEY_WORDS);

    logic [1:0]   mode_reg;
    aesbe_pkg::ctrl_state_t state_reg, state_next;
    logic [3:0]   round_reg, round_next;
    logic [3:0]   byte_reg, byte_next;
    logic [3:0]   nr;
    logic [127:0] plain_reg;
    logic [127:0] state_q;
    logic [127:0] out_reg;
    logic         out_valid_reg;
    logic [5:0]   ki;
    logic [5:0]   rd_idx;
    logic [AW-1:0] rd_addr;
    logic [31:0]  rd_data;
    logic [31:0]  key_word;
    logic         rd_oob_reg;
    logic         wr_en;
    logic         accept;
    aesbe_pkg::dp_ctrl_t ctrl;

    assign ki     = s_tdata[5:0];
    assign accept = s_tvalid && s_tready;
    assign wr_en  = accept && (s_tuser == aesbe_pkg::REQ_KEY) && (32'(ki) < KEY_WORDS);

    // Mode register; 3 saturates to 14 rounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= aesbe_pkg::MODE_128;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        case (mode_reg)
            aesbe_pkg::MODE_128: nr = 4'd10;
            aesbe_pkg::MODE_192: nr = 4'd12;
            default:             nr = 4'd14;
        endcase
    end

    // Key read address: word for the column handled next cycle
    assign rd_idx  = {round_next, byte_next[3:2]};
    assign rd_addr = rd_idx[AW-1:0];

    aesbe_keystore #(.KEY_WORDS(KEY_WORDS)) u_keys (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ki[AW-1:0]),
        .wr_data (s_tdata[37:6]),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Plaintext held with column 0 in the top bits
    always_ff @(posedge clk)
    begin
        rd_oob_reg <= (32'(rd_idx) >= KEY_WORDS);
        if (accept)
        begin
            plain_reg <= {s_tdata[69:38], s_tdata[101:70], s_tdata[133:102],
                          s_tdata[165:134]};
        end
    end
    assign key_word = rd_oob_reg ? 32'd0 : rd_data;

    // Sequencer: state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aesbe_pkg::ST_IDLE;
            round_reg <= '0;
            byte_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            byte_reg  <= byte_next;
        end
    end

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        byte_next  = byte_reg;
        s_tready   = 1'b0;
        ctrl       = '0;
        case (state_reg)
            aesbe_pkg::ST_IDLE:
            begin
                s_tready = !out_valid_reg;
                if (s_tvalid && !out_valid_reg && s_tuser == aesbe_pkg::REQ_ENC)
                begin
                    state_next = aesbe_pkg::ST_LOAD;
                    round_next = 4'd0;
                    byte_next  = 4'd0;
                end
            end
            aesbe_pkg::ST_LOAD:
            begin
                // Initial key addition, words 0..3 come one at a time
                ctrl.load = 1'b1;
                byte_next = byte_reg + 4'd4;
                if (byte_reg == 4'd12)
                begin
                    state_next = aesbe_pkg::ST_ROUND;
                    round_next = 4'd1;
                    byte_next  = 4'd0;
                end
            end
            aesbe_pkg::ST_ROUND:
            begin
                ctrl.step      = 1'b1;
                ctrl.mix       = (round_reg != nr);
                ctrl.last_byte = (byte_reg == 4'd15);
                byte_next      = byte_reg + 4'd1;
                if (byte_reg == 4'd15)
                begin
                    if (round_reg == nr)
                    begin
                        state_next = aesbe_pkg::ST_OUT;
                    end
                    else
                    begin
                        round_next = round_reg + 4'd1;
                    end
                end
            end
            aesbe_pkg::ST_OUT:
            begin
                state_next = aesbe_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = aesbe_pkg::ST_IDLE;
            end
        endcase
    end

    aesbe_datapath u_dp (
        .clk       (clk),
        .ctrl      (ctrl),
        .load_data (plain_reg),
        .key_word  (key_word),
        .byte_idx  (byte_reg),
        .state_q   (state_q)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == aesbe_pkg::ST_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == aesbe_pkg::ST_OUT)
        begin
            out_reg <= {state_q[31:0], state_q[63:32], state_q[95:64], state_q[127:96]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

// ----- design/aesbe_datapath.sv -----
// Byte-serial AES round datapath: a 16-byte register array of the state.
// Each round step cycle one byte is read through the S-box into a column builder.
// Depends on aesbe_pkg.
module aesbe_datapath (
    input  logic                clk,
    input  aesbe_pkg::dp_ctrl_t ctrl,
    input  logic [127:0]        load_data,
    input  logic [31:0]         key_word,
    input  logic [3:0]          byte_idx,
    output logic [127:0]        state_q
);

    // State as 16 bytes, byte 0 = column 0 row 0 (bits 127:120)
    logic [7:0] st_reg [16];
    logic [7:0] nx_reg [16];
    logic [7:0] col_reg [3];
    logic [7:0] sb_byte;
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] b0, b1, b2, b3;
    logic [1:0] row;
    logic [1:0] col;
    logic [3:0] src;
    logic [31:0] ld_word;

    assign row = byte_idx[1:0];
    assign col = byte_idx[3:2];
    // ShiftRows: row r of column c comes from column c+r
    assign src = {col + row, row};
    assign sb_byte = aesbe_pkg::SBOX[st_reg[src]];

    // Plaintext column for the current load step
    always_comb
    begin
        case (col)
            2'd0:    ld_word = load_data[127:96];
            2'd1:    ld_word = load_data[95:64];
            2'd2:    ld_word = load_data[63:32];
            default: ld_word = load_data[31:0];
        endcase
    end

    // MixColumns once the fourth byte of a column is at hand
    always_comb
    begin
        a0 = col_reg[0];
        a1 = col_reg[1];
        a2 = col_reg[2];
        a3 = sb_byte;
        if (ctrl.mix)
        begin
            b0 = aesbe_pkg::xtime(a0) ^ aesbe_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
            b1 = a0 ^ aesbe_pkg::xtime(a1) ^ aesbe_pkg::xtime(a2) ^ a2 ^ a3;
            b2 = a0 ^ a1 ^ aesbe_pkg::xtime(a2) ^ aesbe_pkg::xtime(a3) ^ a3;
            b3 = aesbe_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aesbe_pkg::xtime(a3);
        end
        else
        begin
            b0 = a0;
            b1 = a1;
            b2 = a2;
            b3 = a3;
        end
    end

    // Column collection and state update
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            // Initial key addition, one column per cycle
            st_reg[{col, 2'd0}] <= ld_word[31:24] ^ key_word[31:24];
            st_reg[{col, 2'd1}] <= ld_word[23:16] ^ key_word[23:16];
            st_reg[{col, 2'd2}] <= ld_word[15:8]  ^ key_word[15:8];
            st_reg[{col, 2'd3}] <= ld_word[7:0]   ^ key_word[7:0];
        end
        else if (ctrl.step)
        begin
            if (row != 2'd3)
            begin
                col_reg[row] <= sb_byte;
            end
            else
            begin
                nx_reg[{col, 2'd0}] <= b0 ^ key_word[31:24];
                nx_reg[{col, 2'd1}] <= b1 ^ key_word[23:16];
                nx_reg[{col, 2'd2}] <= b2 ^ key_word[15:8];
                nx_reg[{col, 2'd3}] <= b3 ^ key_word[7:0];
            end
            if (ctrl.last_byte)
            begin
                for (int i = 0; i < 12; i++)
                begin
                    st_reg[i] <= nx_reg[i];
                end
                st_reg[12] <= b0 ^ key_word[31:24];
                st_reg[13] <= b1 ^ key_word[23:16];
                st_reg[14] <= b2 ^ key_word[15:8];
                st_reg[15] <= b3 ^ key_word[7:0];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < aesbe_pkg::BLOCK_BYTES; i++)
        begin
            state_q[127 - 8 * i -: 8] = st_reg[i];
        end
    end

endmodule

// ----- design/aesbe_keystore.sv -----
// Round-key word memory, one write and one registered read port.
// Depends on nothing beyond its parameter.
module aesbe_keystore #(
    parameter int KEY_WORDS = 60
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(KEY_WORDS)-1:0] wr_addr,
    input  logic [31:0]                  wr_data,
    input  logic [$clog2(KEY_WORDS)-1:0] rd_addr,
    output logic [31:0]                  rd_data
);

    logic [31:0] mem [KEY_WORDS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/aesbe_checker.sv -----
// Port-level checker for the AES encryption core, bound to the top level.
// Depends on aes_block_encrypt_top's port list only.
module aesbe_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    // Result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No new item taken while a result waits
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("ready while result pending");

    // An encrypt item blocks input on the next cycle
    a_enc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("ready right after encrypt");

    // A key write never produces a result next cycle
    a_key_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tuser |=> !$rose(m_tvalid))
        else $error("result after key write");

endmodule

bind aes_block_encrypt_top aesbe_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
